[hdl/bpcr_pkg.sv]
`timescale 1ns / 1ps
package bpcr_pkg;

	// Field and fixed-point formats
	localparam int unsigned FIELD_W     = 24;
	localparam int unsigned RADIUS_W    = 16;
	localparam logic [RADIUS_W-1:0] RADIUS_RESET = 16'd2560;
	localparam int unsigned GUARD_BITS  = 6;
	localparam int unsigned UNIT_BITS   = 16;

	// Square root lanes: one result bit per cell
	localparam int unsigned SQ_BITS     = 30;

	// Divider lanes: one quotient bit per cell
	localparam int unsigned QUOT_BITS   = 17;
	localparam int unsigned DIV_W       = 31;

	typedef struct packed {
		logic [SQ_BITS:0]     rem;
		logic [SQ_BITS-1:0]   root;
		logic [2*SQ_BITS-1:0] rad;
	} sq_lane_t;

	typedef struct packed {
		logic [DIV_W-1:0]     rem;
		logic [QUOT_BITS-1:0] dq;
		logic [DIV_W-1:0]     den;
	} div_lane_t;

endpackage

[hdl/ball_pair_collision_response.sv]
`timescale 1ns / 1ps
// Elastic response for a pair of equal discs (positions and velocities in
// signed Q16.8, 24 bits each).
// Channels: s_axis carries one disc pair per transaction, m_axis returns
// one result per transaction: the updated pair in tdata and the contact
// flag in tuser. cfg_valid/cfg_data writes the disc radius (unsigned Q8.8);
// cfg_ready is always high. Write the radius only while the block is empty.
// Throughput, while the receiver does not stall m_axis:
// one pair per cycle. The depth is set by two rows of cells: 30 square root
// cells (one result bit each) and 17 restoring divider cells (one quotient
// bit each), plus eleven registered stages for differences, squares, row
// loads, products, rounding and the final saturating add.
// Reset clears all valid flags and loads the radius with 10.0.
// When the receiver stalls the whole pipeline holds; s_axis_tready drops
// only while a result waits on m_axis and m_axis_tready is low, so a new
// pair still enters in the same cycle that the waiting result is taken.
module ball_pair_collision_response (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [15:0]  cfg_data,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// first_x, first_y, first_vx, first_vy, second_x, second_y, second_vx, second_vy
	input  logic [191:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// new_first_x, new_first_y, new_first_vx, new_first_vy,
	// new_second_x, new_second_y, new_second_vx, new_second_vy
	output logic [191:0] m_axis_tdata,
	// hit
	output logic         m_axis_tuser
);
	localparam int unsigned SQ    = bpcr_pkg::SQ_BITS;
	localparam int unsigned QB    = bpcr_pkg::QUOT_BITS;
	localparam int unsigned DW    = bpcr_pkg::DIV_W;
	localparam int unsigned GB    = bpcr_pkg::GUARD_BITS;
	localparam int unsigned UB    = bpcr_pkg::UNIT_BITS;
	localparam int unsigned UX_SH = UB + GB - QB;
	localparam int unsigned LAT   = 3 + SQ + 1 + QB + 7;
	localparam int unsigned MAG_W = 62;
	localparam int unsigned RM_W  = 30;

	// Disc layout matches the stream packing: x in the lowest bits
	typedef struct packed {
		logic signed [23:0] vy;
		logic signed [23:0] vx;
		logic signed [23:0] y;
		logic signed [23:0] x;
	} disc_t;

	typedef struct packed {
		disc_t b;
		disc_t a;
	} pair_t;

	// Everything a pair carries alongside the arithmetic rows
	typedef struct packed {
		pair_t              p;
		logic [16:0]        adx;
		logic [16:0]        ady;
		logic               sx;
		logic               sy;
		logic signed [24:0] dvx;
		logic signed [24:0] dvy;
		logic               mov;
		logic               hit;
		logic               zero;
		logic [22:0]        dh;
		logic               szero;
	} side_t;

	function automatic logic [23:0] add_sat(input logic signed [23:0] base,
	                                        input logic [RM_W-1:0] mag,
	                                        input logic sub);
		logic signed [31:0] b;
		logic signed [31:0] m;
		logic signed [31:0] s;
		b = 32'(base);
		m = 32'(mag);
		s = sub ? b - m : b + m;
		if (s > 32'sd8388607) begin
			return 24'h7FFFFF;
		end else if (s < -32'sd8388608) begin
			return 24'h800000;
		end
		return s[23:0];
	endfunction

	logic                          en;
	logic [LAT-1:0]                vld_q;
	logic [bpcr_pkg::RADIUS_W-1:0] radius_q;
	logic [16:0]                   twor;

	// Global advance: move when the output slot is free or being taken
	assign en            = !vld_q[LAT-1] || m_axis_tready;
	assign s_axis_tready = en;
	assign m_axis_tvalid = vld_q[LAT-1];
	assign cfg_ready     = 1'b1;
	assign twor          = {radius_q, 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], s_axis_tvalid};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= bpcr_pkg::RADIUS_RESET;
		end else if (cfg_valid) begin
			radius_q <= cfg_data;
		end
	end

	// ---------------------------------------------------------------
	// Stage 1: center and velocity differences
	// ---------------------------------------------------------------
	pair_t              in_pair;
	side_t              side_n1, side_s1;
	logic signed [24:0] dx_n1, dy_n1, dx_s1, dy_s1;

	assign in_pair = pair_t'(s_axis_tdata);

	always_comb begin
		side_n1     = '0;
		side_n1.p   = in_pair;
		dx_n1       = in_pair.a.x - in_pair.b.x;
		dy_n1       = in_pair.a.y - in_pair.b.y;
		side_n1.dvx = in_pair.a.vx - in_pair.b.vx;
		side_n1.dvy = in_pair.a.vy - in_pair.b.vy;
		side_n1.mov = |{in_pair.a.vx, in_pair.a.vy, in_pair.b.vx, in_pair.b.vy};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= side_n1;
			dx_s1   <= dx_n1;
			dy_s1   <= dy_n1;
		end
	end

	// ---------------------------------------------------------------
	// Stage 2: squares of the differences, the speeds and the contact radius
	// ---------------------------------------------------------------
	logic signed [49:0] dxx, dyy;
	logic signed [47:0] axx, ayy, bxx, byy;
	logic [33:0]        tr2_n;
	logic [24:0]        adx_full, ady_full;
	side_t              side_n2, side_s2;
	logic [48:0]        dx2_s2, dy2_s2;
	logic [46:0]        ax2_s2, ay2_s2, bx2_s2, by2_s2;
	logic [33:0]        tr2_s2;

	always_comb begin
		dxx         = dx_s1 * dx_s1;
		dyy         = dy_s1 * dy_s1;
		axx         = side_s1.p.a.vx * side_s1.p.a.vx;
		ayy         = side_s1.p.a.vy * side_s1.p.a.vy;
		bxx         = side_s1.p.b.vx * side_s1.p.b.vx;
		byy         = side_s1.p.b.vy * side_s1.p.b.vy;
		tr2_n       = twor * twor;
		adx_full    = dx_s1[24] ? 25'(-dx_s1) : 25'(dx_s1);
		ady_full    = dy_s1[24] ? 25'(-dy_s1) : 25'(dy_s1);
		side_n2     = side_s1;
		side_n2.sx  = dx_s1[24];
		side_n2.sy  = dy_s1[24];
		// only meaningful on contact, where |dx| <= 2 * radius
		side_n2.adx = adx_full[16:0];
		side_n2.ady = ady_full[16:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s2 <= side_n2;
			dx2_s2  <= dxx[48:0];
			dy2_s2  <= dyy[48:0];
			ax2_s2  <= axx[46:0];
			ay2_s2  <= ayy[46:0];
			bx2_s2  <= bxx[46:0];
			by2_s2  <= byy[46:0];
			tr2_s2  <= tr2_n;
		end
	end

	// ---------------------------------------------------------------
	// Stage 3: exact contact test, load the square root rows
	// Lane 0: distance, lane 1: speed of disc a, lane 2: speed of disc b
	// ---------------------------------------------------------------
	bpcr_pkg::sq_lane_t sq [0:2][0:SQ];
	side_t              side_sq [0:SQ];
	logic [49:0]        dist2;
	logic [47:0]        spa, spb;
	side_t              side_n3;

	always_comb begin
		dist2        = {1'b0, dx2_s2} + {1'b0, dy2_s2};
		spa          = {1'b0, ax2_s2} + {1'b0, ay2_s2};
		spb          = {1'b0, bx2_s2} + {1'b0, by2_s2};
		side_n3      = side_s2;
		side_n3.hit  = dist2 <= {16'b0, tr2_s2};
		side_n3.zero = dist2 == '0;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_sq[0]   <= side_n3;
			sq[0][0].rem  <= '0;
			sq[0][0].root <= '0;
			// on contact the squared distance fits in 34 bits
			sq[0][0].rad  <= {14'b0, dist2[33:0], {(2*GB){1'b0}}};
			sq[1][0].rem  <= '0;
			sq[1][0].root <= '0;
			sq[1][0].rad  <= {spa, {(2*GB){1'b0}}};
			sq[2][0].rem  <= '0;
			sq[2][0].root <= '0;
			sq[2][0].rad  <= {spb, {(2*GB){1'b0}}};
		end
	end

	genvar gl, gi;
	for (gl = 0; gl < 3; gl++) begin : g_sq_lane
		for (gi = 0; gi < SQ; gi++) begin : g_cell
			bpcr_sqrt_cell u_cell (
				.clk    (clk),
				.en     (en),
				.lane_i (sq[gl][gi]),
				.lane_q (sq[gl][gi+1])
			);
		end
	end

	for (gi = 0; gi < SQ; gi++) begin : g_sq_side
		always_ff @(posedge clk) begin
			if (en) begin
				side_sq[gi+1] <= side_sq[gi];
			end
		end
	end

	// ---------------------------------------------------------------
	// Divider load: unit vector x, unit vector y, share k
	// ---------------------------------------------------------------
	bpcr_pkg::div_lane_t dv [0:2][0:QB];
	side_t               side_dv [0:QB];
	logic [22:0]         dh_n;
	logic [SQ-1:0]       spd_a, spd_b;
	logic [SQ:0]         spd_sum;
	side_t               side_nd;

	always_comb begin
		dh_n          = sq[0][SQ].root[22:0];
		spd_a         = sq[1][SQ].root;
		spd_b         = sq[2][SQ].root;
		spd_sum       = {1'b0, spd_a} + {1'b0, spd_b};
		side_nd       = side_sq[SQ];
		side_nd.dh    = dh_n;
		side_nd.szero = spd_sum == '0;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_dv[0]   <= side_nd;
			// dividend |d| << 22; its upper part stays below the divisor
			dv[0][0].rem <= DW'({side_nd.adx, {UX_SH{1'b0}}});
			dv[0][0].dq  <= '0;
			dv[0][0].den <= DW'(dh_n);
			dv[1][0].rem <= DW'({side_nd.ady, {UX_SH{1'b0}}});
			dv[1][0].dq  <= '0;
			dv[1][0].den <= DW'(dh_n);
			// dividend speed_a << 16 over the speed sum
			dv[2][0].rem <= DW'(spd_a[SQ-1:1]);
			dv[2][0].dq  <= {spd_a[0], {UB{1'b0}}};
			dv[2][0].den <= DW'(spd_sum);
		end
	end

	for (gl = 0; gl < 3; gl++) begin : g_dv_lane
		for (gi = 0; gi < QB; gi++) begin : g_cell
			bpcr_div_cell u_cell (
				.clk    (clk),
				.en     (en),
				.lane_i (dv[gl][gi]),
				.lane_q (dv[gl][gi+1])
			);
		end
	end

	for (gi = 0; gi < QB; gi++) begin : g_dv_side
		always_ff @(posedge clk) begin
			if (en) begin
				side_dv[gi+1] <= side_dv[gi];
			end
		end
	end

	// ---------------------------------------------------------------
	// Stage 4: signed unit vector, share and overlap
	// ---------------------------------------------------------------
	side_t              side_s4, side_s5, side_s6, side_s7, side_s8, side_s9;
	logic signed [17:0] qx, qy, ux_n, uy_n;
	logic [16:0]        k_n;
	logic signed [17:0] ux_s4, uy_s4;
	logic [16:0]        k_s4, kc_s4;
	logic signed [23:0] pen_s4;

	always_comb begin
		qx   = $signed({1'b0, dv[0][QB].dq});
		qy   = $signed({1'b0, dv[1][QB].dq});
		ux_n = side_dv[QB].sx ? -qx : qx;
		uy_n = side_dv[QB].sy ? -qy : qy;
		// both discs still: split the push evenly
		k_n  = side_dv[QB].szero ? 17'(1 << (UB - 1)) : dv[2][QB].dq;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s4 <= side_dv[QB];
			ux_s4   <= ux_n;
			uy_s4   <= uy_n;
			k_s4    <= k_n;
			kc_s4   <= 17'((18'd1 << UB) - {1'b0, k_n});
			pen_s4  <= $signed({1'b0, twor, {GB{1'b0}}}) - $signed({1'b0, side_dv[QB].dh});
		end
	end

	// ---------------------------------------------------------------
	// Stage 5: projections of relative velocity and overlap
	// ---------------------------------------------------------------
	logic signed [42:0] mdx_n, mdy_n, mdx_s5, mdy_s5;
	logic signed [41:0] px_n, py_n, px_s5, py_s5, px_s6, py_s6;
	logic signed [17:0] ux_s5, uy_s5, ux_s6, uy_s6;
	logic [16:0]        k_s5, kc_s5, k_s6, kc_s6;

	always_comb begin
		mdx_n = side_s4.dvx * ux_s4;
		mdy_n = side_s4.dvy * uy_s4;
		px_n  = pen_s4 * ux_s4;
		py_n  = pen_s4 * uy_s4;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s5 <= side_s4;
			mdx_s5  <= mdx_n;
			mdy_s5  <= mdy_n;
			px_s5   <= px_n;
			py_s5   <= py_n;
			ux_s5   <= ux_s4;
			uy_s5   <= uy_s4;
			k_s5    <= k_s4;
			kc_s5   <= kc_s4;
		end
	end

	// ---------------------------------------------------------------
	// Stage 6: dot product
	// ---------------------------------------------------------------
	logic signed [43:0] dot_n, dot_s6;

	assign dot_n = mdx_s5 + mdy_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			side_s6 <= side_s5;
			dot_s6  <= dot_n;
			px_s6   <= px_s5;
			py_s6   <= py_s5;
			ux_s6   <= ux_s5;
			uy_s6   <= uy_s5;
			k_s6    <= k_s5;
			kc_s6   <= kc_s5;
		end
	end

	// ---------------------------------------------------------------
	// Stage 7: exchanged velocity and weighted moves, full width
	// 0: ex, 1: ey, 2: move a x, 3: move a y, 4: move b x, 5: move b y
	// ---------------------------------------------------------------
	logic signed [MAG_W-1:0] raw_n [0:5];
	logic signed [MAG_W-1:0] raw_s7 [0:5];
	logic signed [17:0]      ks, kcs;

	always_comb begin
		ks       = $signed({1'b0, k_s6});
		kcs      = $signed({1'b0, kc_s6});
		raw_n[0] = dot_s6 * ux_s6;
		raw_n[1] = dot_s6 * uy_s6;
		raw_n[2] = px_s6 * ks;
		raw_n[3] = py_s6 * ks;
		raw_n[4] = px_s6 * kcs;
		raw_n[5] = py_s6 * kcs;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s7 <= side_s6;
			raw_s7  <= raw_n;
		end
	end

	// ---------------------------------------------------------------
	// Stages 8 and 9: round to nearest, ties away from zero, on magnitudes
	// ---------------------------------------------------------------
	logic [MAG_W-1:0] mag_s8 [0:5];
	logic             neg_s8 [0:5];
	logic             neg_s9 [0:5];
	logic [RM_W-1:0]  rm_s9 [0:5];

	for (gi = 0; gi < 6; gi++) begin : g_rnd
		localparam int unsigned SH = (gi < 2) ? 2 * UB : GB + 2 * UB;
		logic [MAG_W:0] rsum;

		assign rsum = {1'b0, mag_s8[gi]} + ((MAG_W + 1)'(1) << (SH - 1));

		always_ff @(posedge clk) begin
			if (en) begin
				neg_s8[gi] <= raw_s7[gi][MAG_W-1];
				mag_s8[gi] <= raw_s7[gi][MAG_W-1] ? MAG_W'(-raw_s7[gi])
				                                 : MAG_W'(raw_s7[gi]);
				neg_s9[gi] <= neg_s8[gi];
				rm_s9[gi]  <= RM_W'(rsum >> SH);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s8 <= side_s7;
			side_s9 <= side_s8;
		end
	end

	// ---------------------------------------------------------------
	// Stage 10: apply, saturate, hold in the output register
	// ---------------------------------------------------------------
	pair_t out_n, out_pair_q;
	logic  out_hit_q;
	logic  act, vex;
	pair_t pi;

	always_comb begin
		pi    = side_s9.p;
		act   = side_s9.hit && !side_s9.zero;
		vex   = act && side_s9.mov;
		out_n = pi;
		if (act) begin
			out_n.a.x = add_sat(pi.a.x, rm_s9[2], neg_s9[2]);
			out_n.a.y = add_sat(pi.a.y, rm_s9[3], neg_s9[3]);
			out_n.b.x = add_sat(pi.b.x, rm_s9[4], !neg_s9[4]);
			out_n.b.y = add_sat(pi.b.y, rm_s9[5], !neg_s9[5]);
		end
		if (vex) begin
			out_n.a.vx = add_sat(pi.a.vx, rm_s9[0], !neg_s9[0]);
			out_n.a.vy = add_sat(pi.a.vy, rm_s9[1], !neg_s9[1]);
			out_n.b.vx = add_sat(pi.b.vx, rm_s9[0], neg_s9[0]);
			out_n.b.vy = add_sat(pi.b.vy, rm_s9[1], neg_s9[1]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_pair_q <= out_n;
			out_hit_q  <= side_s9.hit;
		end
	end

	assign m_axis_tdata = out_pair_q;
	assign m_axis_tuser = out_hit_q;

endmodule

[hdl/bpcr_sqrt_cell.sv]
`timescale 1ns / 1ps
// One digit of a restoring integer square root: bring down two radicand bits,
// try (root*4 + 1), keep one root bit.
module bpcr_sqrt_cell (
	input  logic                clk,
	input  logic                en,
	input  bpcr_pkg::sq_lane_t  lane_i,
	output bpcr_pkg::sq_lane_t  lane_q
);
	localparam int unsigned N  = bpcr_pkg::SQ_BITS;
	localparam int unsigned RW = N + 1;

	logic [N+2:0]       trial_rem;
	logic [N+2:0]       trial;
	logic               fits;
	bpcr_pkg::sq_lane_t nxt;

	always_comb begin
		trial_rem = {lane_i.rem, lane_i.rad[2*N-1 -: 2]};
		trial     = {1'b0, lane_i.root, 2'b01};
		fits      = trial_rem >= trial;
		nxt.rem   = fits ? RW'(trial_rem - trial) : RW'(trial_rem);
		nxt.root  = {lane_i.root[N-2:0], fits};
		nxt.rad   = {lane_i.rad[2*N-3:0], 2'b00};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lane_q <= nxt;
		end
	end

endmodule

[hdl/bpcr_div_cell.sv]
`timescale 1ns / 1ps
// One step of restoring division: shift in the next dividend bit, subtract
// the divisor when it fits, shift the quotient bit in at the bottom.
module bpcr_div_cell (
	input  logic                clk,
	input  logic                en,
	input  bpcr_pkg::div_lane_t lane_i,
	output bpcr_pkg::div_lane_t lane_q
);
	localparam int unsigned W  = bpcr_pkg::DIV_W;
	localparam int unsigned QB = bpcr_pkg::QUOT_BITS;

	logic [W:0]          trial;
	logic [W:0]          den_x;
	logic                fits;
	bpcr_pkg::div_lane_t nxt;

	always_comb begin
		trial   = {lane_i.rem, lane_i.dq[QB-1]};
		den_x   = {1'b0, lane_i.den};
		fits    = trial >= den_x;
		nxt.rem = fits ? W'(trial - den_x) : W'(trial);
		nxt.dq  = {lane_i.dq[QB-2:0], fits};
		nxt.den = lane_i.den;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lane_q <= nxt;
		end
	end

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
module tb;

	// One disc pair as it travels on s_axis_tdata, first_x in the lowest bits
	typedef struct packed {
		logic [bpcr_pkg::FIELD_W-1:0] vy2, vx2, y2, x2, vy1, vx1, y1, x1;
	} disc_pair_t;

	typedef struct packed {
		logic       hit;
		disc_pair_t discs;
	} response_t;

	typedef struct {
		disc_pair_t pair;
		bit         known;
		bit         known_hit;
	} stim_row_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic [bpcr_pkg::RADIUS_W-1:0] cfg_data = '0;
	logic                          s_axis_tvalid = 1'b0;
	logic                          s_axis_tready;
	logic [191:0]                  s_axis_tdata = '0;
	logic                          m_axis_tvalid;
	logic                          m_axis_tready = 1'b0;
	logic [191:0]                  m_axis_tdata;
	logic                          m_axis_tuser;

	response_t                     pending_responses[$];
	logic [bpcr_pkg::RADIUS_W-1:0] radius_shadow = bpcr_pkg::RADIUS_RESET;
	int                            mismatches = 0;
	int                            stall_left = 0;
	int                            burst_left = 0;

	ball_pair_collision_response uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		#20ms;
		$display("FAILED: results differ");
		$finish;
	end

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned rem, res, bits;
		rem = v;
		res = 0;
		bits = 64'd1 << 62;
		while (bits > rem)
			bits >>= 2;
		while (bits != 0) begin
			if (rem >= res + bits) begin
				rem -= res + bits;
				res = (res >> 1) + bits;
			end else begin
				res >>= 1;
			end
			bits >>= 2;
		end
		return res;
	endfunction

	// Round v / 2^s to nearest, ties away from zero
	function automatic longint round_shift(longint v, int s);
		longint unsigned mag;
		mag = (v < 0) ? -v : v;
		mag = (mag + (64'd1 << (s - 1))) >> s;
		return (v < 0) ? -longint'(mag) : longint'(mag);
	endfunction

	function automatic logic [bpcr_pkg::FIELD_W-1:0] clamp24(longint v);
		if (v > 64'sd8388607)
			return 24'h7FFFFF;
		if (v < -64'sd8388608)
			return 24'h800000;
		return v[bpcr_pkg::FIELD_W-1:0];
	endfunction

	// Equal-mass elastic response of one disc pair at the given radius
	function automatic response_t collide(disc_pair_t p,
			logic [bpcr_pkg::RADIUS_W-1:0] rad);
		longint x1, y1, v1x, v1y, x2, y2, v2x, v2y, dx, dy;
		longint dh, ux, uy, dot, ex, ey, pen, k, px, py;
		longint unsigned dist2, twor, s1, s2;
		int gb, ub;
		response_t r;
		gb = bpcr_pkg::GUARD_BITS;
		ub = bpcr_pkg::UNIT_BITS;
		x1 = $signed(p.x1);   y1 = $signed(p.y1);
		v1x = $signed(p.vx1); v1y = $signed(p.vy1);
		x2 = $signed(p.x2);   y2 = $signed(p.y2);
		v2x = $signed(p.vx2); v2y = $signed(p.vy2);
		dx = x1 - x2;
		dy = y1 - y2;
		dist2 = dx * dx + dy * dy;
		twor = 2 * longint'(rad);
		r.hit = dist2 <= twor * twor;
		if (r.hit && dist2 != 0) begin
			dh = int_sqrt(dist2 << (2 * gb));
			ux = (dx * (64'sd1 << (ub + gb))) / dh;
			uy = (dy * (64'sd1 << (ub + gb))) / dh;
			s1 = int_sqrt((v1x * v1x + v1y * v1y) << (2 * gb));
			s2 = int_sqrt((v2x * v2x + v2y * v2y) << (2 * gb));
			// Exchange only when something moves
			if (v1x != 0 || v1y != 0 || v2x != 0 || v2y != 0) begin
				dot = (v1x - v2x) * ux + (v1y - v2y) * uy;
				ex = round_shift(dot * ux, 2 * ub);
				ey = round_shift(dot * uy, 2 * ub);
				v1x -= ex; v1y -= ey;
				v2x += ex; v2y += ey;
			end
			// Split the push by speed, evenly when both are still
			if (s1 + s2 != 0)
				k = (s1 << ub) / (s1 + s2);
			else
				k = 64'sd1 << (ub - 1);
			pen = longint'(twor << gb) - dh;
			px = pen * ux;
			py = pen * uy;
			x1 += round_shift(px * k, gb + 2 * ub);
			y1 += round_shift(py * k, gb + 2 * ub);
			x2 -= round_shift(px * ((64'sd1 << ub) - k), gb + 2 * ub);
			y2 -= round_shift(py * ((64'sd1 << ub) - k), gb + 2 * ub);
		end
		r.discs.x1 = clamp24(x1);   r.discs.y1 = clamp24(y1);
		r.discs.vx1 = clamp24(v1x); r.discs.vy1 = clamp24(v1y);
		r.discs.x2 = clamp24(x2);   r.discs.y2 = clamp24(y2);
		r.discs.vx2 = clamp24(v2x); r.discs.vy2 = clamp24(v2y);
		return r;
	endfunction

	function automatic disc_pair_t mk(int x1, int y1, int vx1, int vy1,
			int x2, int y2, int vx2, int vy2);
		disc_pair_t p;
		p.x1 = x1[23:0]; p.y1 = y1[23:0]; p.vx1 = vx1[23:0]; p.vy1 = vy1[23:0];
		p.x2 = x2[23:0]; p.y2 = y2[23:0]; p.vx2 = vx2[23:0]; p.vy2 = vy2[23:0];
		return p;
	endfunction

	function automatic int rand_speed();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 2)
			return 0;
		if (sel < 7)
			return int'($urandom_range(0, 4096)) - 2048;
		return int'({{8{1'b0}}, 24'($urandom)} << 8) >>> 8;
	endfunction

	// Mostly pairs within reach of each other, some pure noise
	function automatic disc_pair_t rand_pair(logic [bpcr_pkg::RADIUS_W-1:0] rad);
		disc_pair_t p;
		int reach, cx, cy, sel;
		sel = $urandom_range(0, 99);
		if (sel < 20) begin
			p = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
			return p;
		end
		reach = 3 * int'(rad) + 4;
		if (sel < 30) begin
			// Near the edges of the field so pushes can saturate
			cx = $urandom_range(0, 1) ? 8388607 - int'($urandom_range(0, 4 * reach))
				: -8388608 + int'($urandom_range(0, 4 * reach));
			cy = $urandom_range(0, 1) ? 8388607 - int'($urandom_range(0, 4 * reach))
				: -8388608 + int'($urandom_range(0, 4 * reach));
		end else begin
			cx = int'($urandom_range(0, 8388607)) - 4194304;
			cy = int'($urandom_range(0, 8388607)) - 4194304;
		end
		return mk(cx, cy, rand_speed(), rand_speed(),
			cx + int'($urandom_range(0, 2 * reach)) - reach,
			cy + int'($urandom_range(0, 2 * reach)) - reach,
			rand_speed(), rand_speed());
	endfunction

	function automatic int idle_len();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 55)
			return 0;
		if (sel < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Present one pair and hold it until the transaction completes
	task automatic send_pair(disc_pair_t p);
		int gap;
		gap = (burst_left > 0) ? 0 : idle_len();
		if (burst_left > 0)
			burst_left--;
		else if ($urandom_range(0, 99) == 0)
			burst_left = $urandom_range(20, 80);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= p;
		do @(posedge clk); while (!s_axis_tready);
		pending_responses.insert(pending_responses.size(), collide(p, radius_shadow));
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (pending_responses.size() != 0)
			@(posedge clk);
		repeat (70) @(posedge clk);
	endtask

	task automatic write_radius(logic [bpcr_pkg::RADIUS_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		radius_shadow = value;
	endtask

	// Compare each result transaction with the oldest expectation
	always @(posedge clk) begin
		response_t want, got;
		if (m_axis_tvalid && m_axis_tready) begin
			got.hit = m_axis_tuser;
			got.discs = m_axis_tdata;
			if (pending_responses.size() == 0) begin
				$error("result transaction with nothing expected");
				mismatches++;
			end else begin
				want = pending_responses.pop_front();
				if (got != want) begin
					mismatches++;
					if (got.hit != want.hit)
						$error("hit exp %0d got %0d", want.hit, got.hit);
					if (got.discs.x1 != want.discs.x1)
						$error("new_first_x exp %h got %h", want.discs.x1, got.discs.x1);
					if (got.discs.y1 != want.discs.y1)
						$error("new_first_y exp %h got %h", want.discs.y1, got.discs.y1);
					if (got.discs.vx1 != want.discs.vx1)
						$error("new_first_vx exp %h got %h", want.discs.vx1, got.discs.vx1);
					if (got.discs.vy1 != want.discs.vy1)
						$error("new_first_vy exp %h got %h", want.discs.vy1, got.discs.vy1);
					if (got.discs.x2 != want.discs.x2)
						$error("new_second_x exp %h got %h", want.discs.x2, got.discs.x2);
					if (got.discs.y2 != want.discs.y2)
						$error("new_second_y exp %h got %h", want.discs.y2, got.discs.y2);
					if (got.discs.vx2 != want.discs.vx2)
						$error("new_second_vx exp %h got %h", want.discs.vx2, got.discs.vx2);
					if (got.discs.vy2 != want.discs.vy2)
						$error("new_second_vy exp %h got %h", want.discs.vy2, got.discs.vy2);
				end
			end
		end
		// Stall the receiver in random stretches, sometimes not at all
		if (stall_left > 0) begin
			stall_left--;
			m_axis_tready <= 1'b0;
		end else begin
			stall_left = ($urandom_range(0, 3) == 0) ? idle_len() : 0;
			m_axis_tready <= (stall_left == 0);
		end
	end

	initial begin
		stim_row_t rows[$];
		logic [bpcr_pkg::RADIUS_W-1:0] radii[5];
		int waited;

		// No contact and coincident centres are known by sight: both pass unchanged
		rows.insert(rows.size(), '{mk(0, 0, 0, 0, 0, 0, 0, 0), 1, 1});
		rows.insert(rows.size(), '{mk(8388607, 0, 8388607, -8388608, -8388608, 0,
			-8388608, 8388607), 1, 0});
		rows.insert(rows.size(), '{mk(8388607, 8388607, 8388607, 8388607, 8388607,
			8388607, -8388608, -8388608), 1, 1});
		rows.insert(rows.size(), '{mk(0, -8388608, -1, 1, 0, 8388607, 1, -1), 1, 0});
		rows.insert(rows.size(), '{mk(5121, 0, 300, 0, 0, 0, -300, 0), 1, 0});
		rows.insert(rows.size(), '{mk(-8388608, -8388608, 0, 0, -8388608, -8388608,
			5, 5), 1, 1});
		// Exact touch, rest, head-on, one still, diagonal, saturating pushes
		rows.insert(rows.size(), '{mk(5120, 0, -256, 0, 0, 0, 256, 0), 0, 0});
		rows.insert(rows.size(), '{mk(0, 0, 0, 0, 1000, 0, 0, 0), 0, 0});
		rows.insert(rows.size(), '{mk(0, 0, 0, 0, 700, -900, 0, 0), 0, 0});
		rows.insert(rows.size(), '{mk(0, 0, 256, 0, 3000, 0, -256, 0), 0, 0});
		rows.insert(rows.size(), '{mk(0, 0, 0, 0, 2000, 2000, -512, -512), 0, 0});
		rows.insert(rows.size(), '{mk(1, 1, 8388607, 8388607, 0, 0, -8388608,
			-8388608), 0, 0});
		rows.insert(rows.size(), '{mk(8388597, 0, 8388607, 0, 8388597 - 3000, 0,
			-8388608, 0), 0, 0});
		rows.insert(rows.size(), '{mk(-8388608, 8388607, -4000, 4000, -8388608 + 1,
			8388607 - 2, 0, 0), 0, 0});
		rows.insert(rows.size(), '{mk(-2000, 3000, 100, -7, 1500, 1000, -3, 64), 0, 0});

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed rows at the reset radius
		foreach (rows[i]) begin
			send_pair(rows[i].pair);
			if (rows[i].known)
				pending_responses[$] = '{rows[i].known_hit, rows[i].pair};
		end
		// Hold the sender until every result is back
		drain();

		radii = '{16'd1, 16'hFFFF, 16'(($urandom_range(1, 65535))), 16'd256,
			16'(($urandom_range(1, 4000)))};
		foreach (radii[r]) begin
			write_radius(radii[r]);
			repeat (257) send_pair(rand_pair(radius_shadow));
			drain();
		end

		// Settle the pipeline tail, then report
		waited = 0;
		while (pending_responses.size() != 0 && waited < 100000) begin
			@(posedge clk);
			waited++;
		end
		repeat (70) @(posedge clk);
		if (mismatches == 0 && pending_responses.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
